// ----- sv/lav_pkg.sv -----
// lav_pkg: shared widths and fixed-point constants of the look-at view matrix block
// no dependencies; imported by the channel interfaces and every module but lav_cross
`default_nettype none

package lav_pkg;

   localparam int COORD_BITS_DEF = 16;

   // rotation rows are Q2.14
   localparam int UNIT_W   = 16;
   localparam int FRAC_W   = 14;
   localparam int UNIT_ONE = 1 << FRAC_W;

   // translation terms are Q16.8
   localparam int SHIFT_W   = 24;
   localparam int SHIFT_MAX = (1 << (SHIFT_W - 1)) - 1;
   localparam int SHIFT_MIN = -(1 << (SHIFT_W - 1));

   // normalizer: largest magnitude is scaled into [2^29, 2^30)
   localparam int NORM_W   = 30;
   localparam int NORM_POS = NORM_W - 1;
   localparam int SQ_W     = 2 * NORM_W + 2;
   localparam int RES_W    = SQ_W + 1;
   localparam int ROOT_W   = SQ_W / 2;
   localparam int ROOT_STEPS = SQ_W / 2;
   localparam int QUO_W    = FRAC_W + 1;
   localparam int NUM_W    = NORM_W + FRAC_W + 1;
   localparam int DSH_W    = ROOT_W + QUO_W;

endpackage

`default_nettype wire

// ----- sv/lav_chan_if.sv -----
// lav_req_if and lav_rsp_if: valid/ready channels of the look-at view matrix block
// depends on lav_pkg for the default coordinate width and the result widths
`default_nettype none

interface lav_req_if
   import lav_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
);
   logic valid;
   logic ready;
   logic signed [COORD_BITS-1:0] eye_x;
   logic signed [COORD_BITS-1:0] eye_y;
   logic signed [COORD_BITS-1:0] eye_z;
   logic signed [COORD_BITS-1:0] target_x;
   logic signed [COORD_BITS-1:0] target_y;
   logic signed [COORD_BITS-1:0] target_z;
   logic signed [COORD_BITS-1:0] up_x;
   logic signed [COORD_BITS-1:0] up_y;
   logic signed [COORD_BITS-1:0] up_z;

   modport source (
      output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z,
      input  ready
   );
   modport sink (
      input  valid, eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z,
      output ready
   );
endinterface

interface lav_rsp_if
   import lav_pkg::*;
;
   logic valid;
   logic ready;
   logic signed [UNIT_W-1:0]  right_x;
   logic signed [UNIT_W-1:0]  right_y;
   logic signed [UNIT_W-1:0]  right_z;
   logic signed [UNIT_W-1:0]  camup_x;
   logic signed [UNIT_W-1:0]  camup_y;
   logic signed [UNIT_W-1:0]  camup_z;
   logic signed [UNIT_W-1:0]  back_x;
   logic signed [UNIT_W-1:0]  back_y;
   logic signed [UNIT_W-1:0]  back_z;
   logic signed [SHIFT_W-1:0] shift_x;
   logic signed [SHIFT_W-1:0] shift_y;
   logic signed [SHIFT_W-1:0] shift_z;

   modport source (
      output valid, right_x, right_y, right_z, camup_x, camup_y, camup_z,
             back_x, back_y, back_z, shift_x, shift_y, shift_z,
      input  ready
   );
   modport sink (
      input  valid, right_x, right_y, right_z, camup_x, camup_y, camup_z,
             back_x, back_y, back_z, shift_x, shift_y, shift_z,
      output ready
   );
endinterface

`default_nettype wire

// ----- sv/lav_unit.sv -----
// lav_unit: pipelined 3-vector normalizer to Q2.14 (scale, square, root, divide)
// depends on lav_pkg; one vector per cycle while en is high, 52 register stages
`default_nettype none

module lav_unit
   import lav_pkg::*;
#(
   parameter int IN_W   = 17,
   parameter int SIDE_W = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     valid_in,
   input  logic signed [IN_W-1:0]   v_in [3],
   input  logic [SIDE_W-1:0]        side_in,
   output logic                     valid_out,
   output logic signed [UNIT_W-1:0] q_out [3],
   output logic [SIDE_W-1:0]        side_out
);

   localparam int POS_W = $clog2(IN_W);
   localparam int EXT_W = IN_W + NORM_POS;

   typedef struct packed {
      logic [2:0][NORM_W-1:0] mag;
      logic [2:0]             neg;
      logic                   zero;
      logic [SIDE_W-1:0]      side;
   } carry_type;

   // stage a: magnitudes and their maximum
   logic [IN_W-1:0]   a_mag_in [3];
   logic [IN_W-1:0]   a_max_in;
   logic [IN_W-1:0]   a_mag_ff [3];
   logic [IN_W-1:0]   a_max_ff;
   logic [2:0]        a_neg_ff;
   logic [SIDE_W-1:0] a_side_ff;
   logic              a_vld_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_mag_in[i] = v_in[i][IN_W-1] ? IN_W'(-v_in[i]) : IN_W'(v_in[i]);
      end
      a_max_in = a_mag_in[0];
      if (a_mag_in[1] > a_max_in) begin
         a_max_in = a_mag_in[1];
      end
      if (a_mag_in[2] > a_max_in) begin
         a_max_in = a_mag_in[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_mag_ff  <= a_mag_in;
         a_max_ff  <= a_max_in;
         a_neg_ff  <= {v_in[2][IN_W-1], v_in[1][IN_W-1], v_in[0][IN_W-1]};
         a_side_ff <= side_in;
      end
   end

   // stage b: leading one of the maximum
   logic [POS_W-1:0]  b_pos_in;
   logic [IN_W-1:0]   b_mag_ff [3];
   logic [POS_W-1:0]  b_pos_ff;
   logic              b_zero_ff;
   logic [2:0]        b_neg_ff;
   logic [SIDE_W-1:0] b_side_ff;
   logic              b_vld_ff;

   always_comb begin
      b_pos_in = '0;
      for (int b = 0; b < IN_W; b++) begin
         if (a_max_ff[b]) begin
            b_pos_in = POS_W'(b);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (en) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_mag_ff  <= a_mag_ff;
         b_pos_ff  <= b_pos_in;
         b_zero_ff <= (a_max_ff == '0);
         b_neg_ff  <= a_neg_ff;
         b_side_ff <= a_side_ff;
      end
   end

   // stage c: scale so the leading one of the maximum lands on bit 29, truncating
   logic [NORM_W-1:0] c_mag_in [3];
   logic [EXT_W-1:0]  c_ext;
   logic [NORM_W-1:0] c_mag_ff [3];
   logic              c_zero_ff;
   logic [2:0]        c_neg_ff;
   logic [SIDE_W-1:0] c_side_ff;
   logic              c_vld_ff;

   always_comb begin
      c_ext = '0;
      for (int i = 0; i < 3; i++) begin
         c_ext       = {b_mag_ff[i], {NORM_POS{1'b0}}} >> b_pos_ff;
         c_mag_in[i] = c_ext[NORM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (en) begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_mag_ff  <= c_mag_in;
         c_zero_ff <= b_zero_ff;
         c_neg_ff  <= b_neg_ff;
         c_side_ff <= b_side_ff;
      end
   end

   // stage d: squares
   logic [2*NORM_W-1:0] d_sq_ff [3];
   carry_type           d_c_ff;
   logic                d_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (en) begin
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            d_sq_ff[i]     <= c_mag_ff[i] * c_mag_ff[i];
            d_c_ff.mag[i]  <= c_mag_ff[i];
         end
         d_c_ff.neg  <= c_neg_ff;
         d_c_ff.zero <= c_zero_ff;
         d_c_ff.side <= c_side_ff;
      end
   end

   // square root: one result bit per stage, entry 0 holds the sum of squares
   logic [SQ_W-1:0]  rt_n_ff [0:ROOT_STEPS];
   logic [RES_W-1:0] rt_r_ff [0:ROOT_STEPS];
   carry_type        rt_c_ff [0:ROOT_STEPS];
   logic             rt_v_ff [0:ROOT_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         rt_v_ff[0] <= 1'b0;
      end else if (en) begin
         rt_v_ff[0] <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rt_n_ff[0] <= SQ_W'(d_sq_ff[0]) + SQ_W'(d_sq_ff[1]) + SQ_W'(d_sq_ff[2]);
         rt_r_ff[0] <= '0;
         rt_c_ff[0] <= d_c_ff;
      end
   end

   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
      logic [RES_W-1:0] bit_val;
      logic [RES_W-1:0] trial;
      logic [SQ_W-1:0]  n_in;
      logic [RES_W-1:0] r_in;

      always_comb begin
         bit_val = RES_W'(1) << (SQ_W - 2 - 2 * k);
         trial   = rt_r_ff[k] + bit_val;
         if ({1'b0, rt_n_ff[k]} >= trial) begin
            n_in = SQ_W'({1'b0, rt_n_ff[k]} - trial);
            r_in = (rt_r_ff[k] >> 1) + bit_val;
         end else begin
            n_in = rt_n_ff[k];
            r_in = rt_r_ff[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rt_v_ff[k+1] <= 1'b0;
         end else if (en) begin
            rt_v_ff[k+1] <= rt_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rt_n_ff[k+1] <= n_in;
            rt_r_ff[k+1] <= r_in;
            rt_c_ff[k+1] <= rt_c_ff[k];
         end
      end
   end

   // restoring division, one quotient bit per stage, three lanes
   logic [NUM_W-1:0]  dv_rem_ff [0:QUO_W-1][3];
   logic [QUO_W-1:0]  dv_q_ff   [0:QUO_W-1][3];
   logic [ROOT_W-1:0] dv_len_ff [0:QUO_W-1];
   carry_type         dv_c_ff   [0:QUO_W-1];
   logic              dv_v_ff   [0:QUO_W-1];

   for (genvar j = 0; j < QUO_W; j++) begin : g_div
      logic [NUM_W-1:0]  rem_src [3];
      logic [QUO_W-1:0]  q_src   [3];
      logic [ROOT_W-1:0] len_src;
      carry_type         c_src;
      logic              v_src;
      logic [DSH_W-1:0]  dsh;
      logic [NUM_W-1:0]  rem_in  [3];
      logic [QUO_W-1:0]  q_in    [3];

      if (j == 0) begin : g_first
         // numerator carries the rounding half of the divisor
         always_comb begin
            len_src = rt_r_ff[ROOT_STEPS][ROOT_W-1:0];
            c_src   = rt_c_ff[ROOT_STEPS];
            v_src   = rt_v_ff[ROOT_STEPS];
            for (int i = 0; i < 3; i++) begin
               rem_src[i] = NUM_W'({c_src.mag[i], {FRAC_W{1'b0}}}) + NUM_W'(len_src >> 1);
               q_src[i]   = '0;
            end
         end
      end else begin : g_next
         always_comb begin
            len_src = dv_len_ff[j-1];
            c_src   = dv_c_ff[j-1];
            v_src   = dv_v_ff[j-1];
            rem_src = dv_rem_ff[j-1];
            q_src   = dv_q_ff[j-1];
         end
      end

      always_comb begin
         dsh = DSH_W'(len_src) << (QUO_W - 1 - j);
         for (int i = 0; i < 3; i++) begin
            if (DSH_W'(rem_src[i]) >= dsh) begin
               rem_in[i] = NUM_W'(DSH_W'(rem_src[i]) - dsh);
               q_in[i]   = q_src[i] | (QUO_W'(1) << (QUO_W - 1 - j));
            end else begin
               rem_in[i] = rem_src[i];
               q_in[i]   = q_src[i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j] <= 1'b0;
         end else if (en) begin
            dv_v_ff[j] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_rem_ff[j] <= rem_in;
            dv_q_ff[j]   <= q_in;
            dv_len_ff[j] <= len_src;
            dv_c_ff[j]   <= c_src;
         end
      end
   end

   // output: signs back, zero vector stays zero
   logic signed [UNIT_W-1:0] q_in [3];
   logic signed [UNIT_W-1:0] q_ff [3];
   logic [SIDE_W-1:0]        side_ff;
   logic                     vld_ff;
   carry_type                last_c;

   always_comb begin
      last_c = dv_c_ff[QUO_W-1];
      for (int i = 0; i < 3; i++) begin
         if (last_c.zero) begin
            q_in[i] = '0;
         end else if (last_c.neg[i]) begin
            q_in[i] = UNIT_W'(-$signed({1'b0, dv_q_ff[QUO_W-1][i]}));
         end else begin
            q_in[i] = UNIT_W'($signed({1'b0, dv_q_ff[QUO_W-1][i]}));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= dv_v_ff[QUO_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff    <= q_in;
         side_ff <= last_c.side;
      end
   end

   assign valid_out = vld_ff;
   assign q_out     = q_ff;
   assign side_out  = side_ff;

endmodule

`default_nettype wire

// ----- sv/lav_cross.sv -----
// lav_cross: two-stage pipelined cross product a x b with side data
// no package dependency
`default_nettype none

module lav_cross #(
   parameter int A_W    = 16,
   parameter int B_W    = 16,
   parameter int SIDE_W = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       valid_in,
   input  logic signed [A_W-1:0]      a_in [3],
   input  logic signed [B_W-1:0]      b_in [3],
   input  logic [SIDE_W-1:0]          side_in,
   output logic                       valid_out,
   output logic signed [A_W+B_W:0]    c_out [3],
   output logic [SIDE_W-1:0]          side_out
);

   localparam int P_W = A_W + B_W;
   localparam int C_W = P_W + 1;

   logic signed [P_W-1:0] prod_ff [6];
   logic [SIDE_W-1:0]     side1_ff;
   logic                  vld1_ff;
   logic signed [C_W-1:0] c_ff [3];
   logic [SIDE_W-1:0]     side2_ff;
   logic                  vld2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= valid_in;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff[0] <= a_in[1] * b_in[2];
         prod_ff[1] <= a_in[2] * b_in[1];
         prod_ff[2] <= a_in[2] * b_in[0];
         prod_ff[3] <= a_in[0] * b_in[2];
         prod_ff[4] <= a_in[0] * b_in[1];
         prod_ff[5] <= a_in[1] * b_in[0];
         side1_ff   <= side_in;
         c_ff[0]    <= C_W'(prod_ff[0]) - C_W'(prod_ff[1]);
         c_ff[1]    <= C_W'(prod_ff[2]) - C_W'(prod_ff[3]);
         c_ff[2]    <= C_W'(prod_ff[4]) - C_W'(prod_ff[5]);
         side2_ff   <= side1_ff;
      end
   end

   assign valid_out = vld2_ff;
   assign c_out     = c_ff;
   assign side_out  = side2_ff;

endmodule

`default_nettype wire

// ----- sv/lav_dot.sv -----
// lav_dot: three dot products with eye, rounded to Q16.8 and clamped; result register
// depends on lav_pkg; three register stages
`default_nettype none

module lav_dot
   import lav_pkg::*;
#(
   parameter int E_W = COORD_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      valid_in,
   input  logic signed [UNIT_W-1:0]  r_in [3],
   input  logic signed [UNIT_W-1:0]  u_in [3],
   input  logic signed [UNIT_W-1:0]  d_in [3],
   input  logic signed [E_W-1:0]     eye_in [3],
   output logic                      valid_out,
   output logic signed [UNIT_W-1:0]  right_out [3],
   output logic signed [UNIT_W-1:0]  camup_out [3],
   output logic signed [UNIT_W-1:0]  back_out [3],
   output logic signed [SHIFT_W-1:0] shift_out [3]
);

   localparam int P_W   = UNIT_W + E_W;
   localparam int S_W   = P_W + 2;
   localparam int M_W   = S_W + 1 - FRAC_W;
   localparam int CMP_W = (M_W > SHIFT_W ? M_W : SHIFT_W) + 1;
   // right and up terms are negated, the forward term is not
   localparam logic [2:0] LANE_NEG = 3'b011;

   logic signed [P_W-1:0]    prod_ff [3][3];
   logic signed [UNIT_W-1:0] r1_ff [3];
   logic signed [UNIT_W-1:0] u1_ff [3];
   logic signed [UNIT_W-1:0] d1_ff [3];
   logic                     vld1_ff;

   logic signed [S_W-1:0]    sum_ff [3];
   logic signed [UNIT_W-1:0] r2_ff [3];
   logic signed [UNIT_W-1:0] u2_ff [3];
   logic signed [UNIT_W-1:0] d2_ff [3];
   logic                     vld2_ff;

   logic signed [SHIFT_W-1:0] shift_in [3];
   logic signed [SHIFT_W-1:0] shift_ff [3];
   logic signed [UNIT_W-1:0]  r3_ff [3];
   logic signed [UNIT_W-1:0]  u3_ff [3];
   logic signed [UNIT_W-1:0]  b3_ff [3];
   logic                      vld3_ff;

   logic [S_W-1:0]           mag;
   logic [S_W:0]             rnd;
   logic [M_W-1:0]           m;
   logic signed [CMP_W-1:0]  val;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= valid_in;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            prod_ff[0][i] <= r_in[i] * eye_in[i];
            prod_ff[1][i] <= u_in[i] * eye_in[i];
            prod_ff[2][i] <= d_in[i] * eye_in[i];
         end
         r1_ff <= r_in;
         u1_ff <= u_in;
         d1_ff <= d_in;
         for (int l = 0; l < 3; l++) begin
            sum_ff[l] <= S_W'(prod_ff[l][0]) + S_W'(prod_ff[l][1]) + S_W'(prod_ff[l][2]);
         end
         r2_ff <= r1_ff;
         u2_ff <= u1_ff;
         d2_ff <= d1_ff;
      end
   end

   // round half away from zero, apply the lane sign, saturate to 24 bits
   always_comb begin
      mag = '0;
      rnd = '0;
      m   = '0;
      val = '0;
      for (int l = 0; l < 3; l++) begin
         mag = sum_ff[l][S_W-1] ? S_W'(-sum_ff[l]) : S_W'(sum_ff[l]);
         rnd = {1'b0, mag} + (S_W+1)'(1 << (FRAC_W - 1));
         m   = rnd[S_W:FRAC_W];
         if (sum_ff[l][S_W-1] ^ LANE_NEG[l]) begin
            val = -$signed(CMP_W'(m));
         end else begin
            val = $signed(CMP_W'(m));
         end
         if (val > CMP_W'(SHIFT_MAX)) begin
            shift_in[l] = SHIFT_W'(SHIFT_MAX);
         end else if (val < CMP_W'(SHIFT_MIN)) begin
            shift_in[l] = SHIFT_W'(SHIFT_MIN);
         end else begin
            shift_in[l] = SHIFT_W'(val);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         shift_ff <= shift_in;
         r3_ff    <= r2_ff;
         u3_ff    <= u2_ff;
         for (int i = 0; i < 3; i++) begin
            b3_ff[i] <= -d2_ff[i];
         end
      end
   end

   assign valid_out = vld3_ff;
   assign right_out = r3_ff;
   assign camup_out = u3_ff;
   assign back_out  = b3_ff;
   assign shift_out = shift_ff;

endmodule

`default_nettype wire

// ----- sv/look_at_view_matrix.sv -----
// look_at_view_matrix: pipelined right-handed look-at view matrix, Q8.8 in, Q2.14/Q16.8 out
// depends on lav_pkg, lav_req_if, lav_rsp_if, lav_unit, lav_cross, lav_dot
//
//   channel | dir | handshake          | payload
//   req_ch  | in  | valid/ready        | eye, target, up (x, y, z), signed Q8.8
//   rsp_ch  | out | valid/ready        | right, camup, back Q2.14; shift Q16.8
//
// one item per cycle sustained while rsp_ch takes each result; latency is dominated by the two normalizers
// (52 stages each: 31 square-root steps and 15 division steps dominate)
// the whole pipe advances when the result register is empty or its transfer completes
// a stall freezes every stage in place; nothing is lost or repeated
// synchronous active-high reset clears all valid bits
`default_nettype none

module look_at_view_matrix
   import lav_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   lav_req_if.sink   req_ch,
   lav_rsp_if.source rsp_ch
);

   localparam int CB     = COORD_BITS;
   localparam int DIR_W  = CB + 1;
   localparam int RC_W   = UNIT_W + CB + 1;
   localparam int UC_W   = 2 * UNIT_W + 1;
   localparam int SIDE1_W = 6 * CB;
   localparam int SIDE2_W = 3 * CB + 3 * UNIT_W;
   localparam int SIDE4_W = 3 * CB + 6 * UNIT_W;

   logic en;
   assign en = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = en;

   // forward direction
   logic signed [CB-1:0]    eye_in [3];
   logic signed [CB-1:0]    tgt_in [3];
   logic signed [CB-1:0]    up_in  [3];
   logic signed [DIR_W-1:0] dir_ff [3];
   logic signed [CB-1:0]    eye0_ff [3];
   logic signed [CB-1:0]    up0_ff  [3];
   logic                    vld0_ff;

   assign eye_in = '{req_ch.eye_x, req_ch.eye_y, req_ch.eye_z};
   assign tgt_in = '{req_ch.target_x, req_ch.target_y, req_ch.target_z};
   assign up_in  = '{req_ch.up_x, req_ch.up_y, req_ch.up_z};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else if (en) begin
         vld0_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            dir_ff[i] <= DIR_W'(tgt_in[i]) - DIR_W'(eye_in[i]);
         end
         eye0_ff <= eye_in;
         up0_ff  <= up_in;
      end
   end

   // normalize forward
   logic [SIDE1_W-1:0]       side1_in;
   logic [SIDE1_W-1:0]       side1_out;
   logic signed [UNIT_W-1:0] d1 [3];
   logic signed [CB-1:0]     eye1 [3];
   logic signed [CB-1:0]     up1  [3];
   logic                     vld1;

   assign side1_in = {eye0_ff[0], eye0_ff[1], eye0_ff[2], up0_ff[0], up0_ff[1], up0_ff[2]};

   lav_unit #(
      .IN_W   (DIR_W),
      .SIDE_W (SIDE1_W)
   ) u_unit_fwd (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (vld0_ff),
      .v_in      (dir_ff),
      .side_in   (side1_in),
      .valid_out (vld1),
      .q_out     (d1),
      .side_out  (side1_out)
   );

   // right before normalizing: forward x up
   logic [SIDE2_W-1:0]       side2_in;
   logic [SIDE2_W-1:0]       side2_out;
   logic signed [RC_W-1:0]   rc [3];
   logic                     vld2;

   assign side2_in = {eye1[0], eye1[1], eye1[2], d1[0], d1[1], d1[2]};

   lav_cross #(
      .A_W    (UNIT_W),
      .B_W    (CB),
      .SIDE_W (SIDE2_W)
   ) u_cross_right (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (vld1),
      .a_in      (d1),
      .b_in      (up1),
      .side_in   (side2_in),
      .valid_out (vld2),
      .c_out     (rc),
      .side_out  (side2_out)
   );

   // normalize right
   logic [SIDE2_W-1:0]       side3_out;
   logic signed [UNIT_W-1:0] r3 [3];
   logic signed [CB-1:0]     eye3 [3];
   logic signed [UNIT_W-1:0] d3 [3];
   logic                     vld3;

   lav_unit #(
      .IN_W   (RC_W),
      .SIDE_W (SIDE2_W)
   ) u_unit_right (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (vld2),
      .v_in      (rc),
      .side_in   (side2_out),
      .valid_out (vld3),
      .q_out     (r3),
      .side_out  (side3_out)
   );

   // camera up: right x forward
   logic [SIDE4_W-1:0]       side4_in;
   logic [SIDE4_W-1:0]       side4_out;
   logic signed [UC_W-1:0]   uc [3];
   logic                     vld4;
   logic signed [CB-1:0]     eye4 [3];
   logic signed [UNIT_W-1:0] r4 [3];
   logic signed [UNIT_W-1:0] d4 [3];

   assign side4_in = {eye3[0], eye3[1], eye3[2], r3[0], r3[1], r3[2], d3[0], d3[1], d3[2]};

   lav_cross #(
      .A_W    (UNIT_W),
      .B_W    (UNIT_W),
      .SIDE_W (SIDE4_W)
   ) u_cross_up (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (vld3),
      .a_in      (r3),
      .b_in      (d3),
      .side_in   (side4_in),
      .valid_out (vld4),
      .c_out     (uc),
      .side_out  (side4_out)
   );

   for (genvar i = 0; i < 3; i++) begin : g_unpack
      assign eye1[i] = side1_out[SIDE1_W - i * CB - 1 -: CB];
      assign up1[i]  = side1_out[(3 - i) * CB - 1 -: CB];
      assign eye3[i] = side3_out[SIDE2_W - i * CB - 1 -: CB];
      assign d3[i]   = side3_out[(3 - i) * UNIT_W - 1 -: UNIT_W];
      assign eye4[i] = side4_out[SIDE4_W - i * CB - 1 -: CB];
      assign r4[i]   = side4_out[(6 - i) * UNIT_W - 1 -: UNIT_W];
      assign d4[i]   = side4_out[(3 - i) * UNIT_W - 1 -: UNIT_W];
   end

   // camera up rescaled from Q5.28 with rounding, saturated to unit range
   logic [UC_W-1:0]          uc_mag;
   logic [UC_W:0]            uc_rnd;
   logic [UC_W-FRAC_W:0]     uc_m;
   logic signed [UNIT_W-1:0] u5_in  [3];
   logic signed [UNIT_W-1:0] u5_ff  [3];
   logic signed [UNIT_W-1:0] r5_ff  [3];
   logic signed [UNIT_W-1:0] d5_ff  [3];
   logic signed [CB-1:0]     eye5_ff [3];
   logic                     vld5_ff;

   always_comb begin
      uc_mag = '0;
      uc_rnd = '0;
      uc_m   = '0;
      for (int i = 0; i < 3; i++) begin
         uc_mag = uc[i][UC_W-1] ? UC_W'(-uc[i]) : UC_W'(uc[i]);
         uc_rnd = {1'b0, uc_mag} + (UC_W+1)'(1 << (FRAC_W - 1));
         uc_m   = uc_rnd[UC_W:FRAC_W];
         if (uc_m > (UC_W-FRAC_W+1)'(UNIT_ONE)) begin
            uc_m = (UC_W-FRAC_W+1)'(UNIT_ONE);
         end
         if (uc[i][UC_W-1]) begin
            u5_in[i] = UNIT_W'(-$signed({1'b0, uc_m}));
         end else begin
            u5_in[i] = UNIT_W'($signed({1'b0, uc_m}));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld5_ff <= 1'b0;
      end else if (en) begin
         vld5_ff <= vld4;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u5_ff   <= u5_in;
         r5_ff   <= r4;
         d5_ff   <= d4;
         eye5_ff <= eye4;
      end
   end

   // translation and result register
   logic signed [UNIT_W-1:0]  right_o [3];
   logic signed [UNIT_W-1:0]  camup_o [3];
   logic signed [UNIT_W-1:0]  back_o  [3];
   logic signed [SHIFT_W-1:0] shift_o [3];

   lav_dot #(
      .E_W (CB)
   ) u_dot (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (vld5_ff),
      .r_in      (r5_ff),
      .u_in      (u5_ff),
      .d_in      (d5_ff),
      .eye_in    (eye5_ff),
      .valid_out (rsp_ch.valid),
      .right_out (right_o),
      .camup_out (camup_o),
      .back_out  (back_o),
      .shift_out (shift_o)
   );

   assign rsp_ch.right_x = right_o[0];
   assign rsp_ch.right_y = right_o[1];
   assign rsp_ch.right_z = right_o[2];
   assign rsp_ch.camup_x = camup_o[0];
   assign rsp_ch.camup_y = camup_o[1];
   assign rsp_ch.camup_z = camup_o[2];
   assign rsp_ch.back_x  = back_o[0];
   assign rsp_ch.back_y  = back_o[1];
   assign rsp_ch.back_z  = back_o[2];
   assign rsp_ch.shift_x = shift_o[0];
   assign rsp_ch.shift_y = shift_o[1];
   assign rsp_ch.shift_z = shift_o[2];

   // a reset empties the result register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_ch.valid)
      else $error("result valid after reset");

   // eye on target leaves every output zero
   a_degenerate: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.back_x == '0 && rsp_ch.back_y == '0 && rsp_ch.back_z == '0)
      |-> (rsp_ch.right_x == '0 && rsp_ch.right_y == '0 && rsp_ch.right_z == '0 &&
           rsp_ch.camup_x == '0 && rsp_ch.camup_y == '0 && rsp_ch.camup_z == '0 &&
           rsp_ch.shift_x == '0 && rsp_ch.shift_y == '0 && rsp_ch.shift_z == '0))
      else $error("nonzero output for zero forward vector");

   // camera up stays inside the unit range after saturation
   a_camup_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |->
         (rsp_ch.camup_x <= UNIT_ONE && rsp_ch.camup_x >= -UNIT_ONE &&
          rsp_ch.camup_y <= UNIT_ONE && rsp_ch.camup_y >= -UNIT_ONE &&
          rsp_ch.camup_z <= UNIT_ONE && rsp_ch.camup_z >= -UNIT_ONE))
      else $error("camera up out of range");

endmodule

`default_nettype wire
